### hdl/wtsc_pkg.sv
// Shared types and constants for the wave table sound channel.
`default_nettype none

package wtsc_pkg;

    localparam int WAVE_BYTES = 16;
    localparam int WAVE_IDX_W = $clog2(WAVE_BYTES);

    // Register addresses, low byte of the 0xFFxx page.
    localparam logic [7:0] ADDR_DAC    = 8'h1A;
    localparam logic [7:0] ADDR_LENGTH = 8'h1B;
    localparam logic [7:0] ADDR_VOLUME = 8'h1C;
    localparam logic [7:0] ADDR_FREQ_LO = 8'h1D;
    localparam logic [7:0] ADDR_FREQ_HI = 8'h1E;
    localparam logic [3:0] WAVE_PAGE   = 4'h3;

    // Fixed bits returned on read-back.
    localparam logic [7:0] DAC_READ_MASK    = 8'h7F;
    localparam logic [7:0] VOLUME_READ_MASK = 8'h9F;
    localparam logic [7:0] FREQ_READ_MASK   = 8'hBF;
    localparam logic [7:0] OPEN_BUS         = 8'hFF;

    localparam logic [11:0] PERIOD_BASE     = 12'd2048;
    localparam logic [12:0] TRIGGER_DELAY   = 13'd6;
    localparam logic [12:0] CORRUPT_TIMER   = 13'd2;
    localparam logic [4:0]  NIBBLE_POS_INIT = 5'd4;
    localparam logic [1:0]  FETCH_WINDOW    = 2'd2;

    typedef enum logic [1:0] {
        KIND_TICK     = 2'd0,
        KIND_READ     = 2'd1,
        KIND_WRITE    = 2'd2,
        KIND_SHUTDOWN = 2'd3
    } kind_t;

    typedef struct packed {
        logic [7:0] reg_wdata;
        logic [7:0] reg_addr;
        kind_t      kind;
    } item_t;

    typedef struct packed {
        logic       channel_on;
        logic [3:0] sample;
        logic [7:0] reg_rdata;
    } result_t;

    typedef struct packed {
        logic dac_on;
        logic enabled;
    } chan_status_t;

endpackage

`default_nettype wire

### hdl/wave_table_sound_channel_top.sv
// Top level of the wave table sound channel: stream ports, input and result registers.
//
// Requests arrive on the s_ group: s_tuser carries the kind (tick, register read,
// register write, power off) and s_tdata the register address and write byte.
// Every request yields exactly one result on the m_ group: the read byte (zero
// for anything but a read), the current output nibble and the channel enable.
// A taken request sits in the input register until the result register is free
// or being drained; it is then applied to the channel state and its result is
// held in the result register, which raises m_tvalid. One request is
// taken every cycle as long as results drain; the state update of each
// request is a single pass through the core logic, which sets that rate.
// When m_tready is low, the result register holds and the input register
// fills, after which s_tready drops until the result is taken.
// Reset clears the channel state and the valid flags of both registers; the
// wave table keeps its contents undefined until written. The user must write color_mode
// via cfg_wen/cfg_wdata only while no request is in flight; the block does not check.
`default_nettype none

module wave_table_sound_channel_top (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_wen,
    input  wire logic        cfg_wdata,     // color_mode
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,       // [7:0] reg_addr, [15:8] reg_wdata
    input  wire logic [1:0]  s_tuser,       // [1:0] kind
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata        // [7:0] reg_rdata, [11:8] sample, [12] channel_on
);

    logic                   color_mode_reg;
    logic                   in_valid_reg;
    wtsc_pkg::item_t        in_item_reg;
    logic                   out_valid_reg;
    wtsc_pkg::result_t      out_result_reg;
    logic                   advance;
    wtsc_pkg::result_t      core_result;
    wtsc_pkg::chan_status_t core_status;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            color_mode_reg <= 1'b0;
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_wen)
            begin
                color_mode_reg <= cfg_wdata;
            end
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_item_reg.kind      <= wtsc_pkg::kind_t'(s_tuser);
            in_item_reg.reg_addr  <= s_tdata[7:0];
            in_item_reg.reg_wdata <= s_tdata[15:8];
        end
        if (advance)
        begin
            out_result_reg <= core_result;
        end
    end

    wtsc_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (advance),
        .item       (in_item_reg),
        .color_mode (color_mode_reg),
        .result     (core_result),
        .status     (core_status)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'd0, out_result_reg.channel_on, out_result_reg.sample,
                       out_result_reg.reg_rdata};

    // A waiting request in the input register is not overwritten.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !advance) |=> (in_valid_reg && $stable(in_item_reg)))
        else $error("input register lost a pending request");

    // Every processed request produces a result on the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> m_tvalid)
        else $error("processed request produced no result");

    // The channel can only be on while its DAC is on.
    assert property (@(posedge clk) disable iff (!rst_n)
        core_status.enabled |-> core_status.dac_on)
        else $error("channel enabled with DAC off");

endmodule

`default_nettype wire

### hdl/wtsc_core.sv
// Channel state and the update that one request applies to it.
`default_nettype none

module wtsc_core (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             step,
    input  wire wtsc_pkg::item_t  item,
    input  wire logic             color_mode,
    output wtsc_pkg::result_t     result,
    output wtsc_pkg::chan_status_t status
);

    logic [7:0]  wave_ram_reg [wtsc_pkg::WAVE_BYTES];

    logic [12:0] timer_reg, timer_next;
    logic [4:0]  nibble_pos_reg, nibble_pos_next;
    logic [1:0]  since_fetch_reg, since_fetch_next;
    logic [3:0]  last_idx_reg, last_idx_next;
    logic [10:0] freq_reg, freq_next;
    logic [1:0]  vol_reg, vol_next;
    logic        dac_reg, dac_next;
    logic        enabled_reg, enabled_next;
    logic        len_en_reg, len_en_next;
    logic [3:0]  held_reg, held_next;

    logic        is_read;
    logic        is_write;
    logic        wave_hit;
    logic        access_open;
    logic [3:0]  rd_idx;
    logic [3:0][7:0] row_data;
    logic [7:0]  rd_byte;
    logic [3:0]  nib_raw;
    logic [3:0]  nib_scaled;
    logic [12:0] reload;
    logic        corrupt;
    logic        corrupt_row;
    logic        corrupt_byte0;
    logic        ram_we;
    logic [7:0]  read_value;

    assign is_read     = (item.kind == wtsc_pkg::KIND_READ);
    assign is_write    = (item.kind == wtsc_pkg::KIND_WRITE);
    assign wave_hit    = (item.reg_addr[7:4] == wtsc_pkg::WAVE_PAGE) && (is_read || is_write);
    assign access_open = (since_fetch_reg < wtsc_pkg::FETCH_WINDOW) || color_mode;

    // One table read per request: the bus address, the last fetched byte, or the
    // byte under the play position for a tick or a trigger.
    always_comb
    begin
        if (wave_hit)
        begin
            rd_idx = enabled_reg ? last_idx_reg : item.reg_addr[3:0];
        end
        else
        begin
            rd_idx = nibble_pos_reg[4:1];
        end
        for (int j = 0; j < 4; j++)
        begin
            row_data[2'(j)] = wave_ram_reg[{rd_idx[3:2], 2'(j)}];
        end
    end

    assign rd_byte = row_data[rd_idx[1:0]];
    assign nib_raw = nibble_pos_reg[0] ? rd_byte[3:0] : rd_byte[7:4];

    always_comb
    begin
        unique case (vol_reg)
            2'd0:    nib_scaled = 4'd0;
            2'd1:    nib_scaled = nib_raw;
            2'd2:    nib_scaled = nib_raw >> 1;
            default: nib_scaled = nib_raw >> 2;
        endcase
    end

    assign reload = {wtsc_pkg::PERIOD_BASE - {1'b0, freq_reg}, 1'b0};

    // A monochrome trigger that lands as a fetch is due copies table bytes to the front.
    assign corrupt = is_write && (item.reg_addr == wtsc_pkg::ADDR_FREQ_HI)
                     && item.reg_wdata[7] && enabled_reg
                     && (timer_reg == wtsc_pkg::CORRUPT_TIMER) && !color_mode;
    assign corrupt_row   = corrupt && (rd_idx[3:2] != 2'd0);
    assign corrupt_byte0 = corrupt && (rd_idx[3:2] == 2'd0);
    assign ram_we        = is_write && wave_hit && (!enabled_reg || access_open);

    always_comb
    begin
        read_value = 8'd0;
        if (is_read)
        begin
            if (wave_hit)
            begin
                if (enabled_reg)
                begin
                    read_value = access_open ? rd_byte : wtsc_pkg::OPEN_BUS;
                end
                else
                begin
                    read_value = rd_byte;
                end
            end
            else
            begin
                unique case (item.reg_addr)
                    wtsc_pkg::ADDR_DAC:     read_value = {dac_reg, 7'd0} | wtsc_pkg::DAC_READ_MASK;
                    wtsc_pkg::ADDR_LENGTH:  read_value = wtsc_pkg::OPEN_BUS;
                    wtsc_pkg::ADDR_VOLUME:
                        read_value = {1'b0, vol_reg, 5'd0} | wtsc_pkg::VOLUME_READ_MASK;
                    wtsc_pkg::ADDR_FREQ_LO: read_value = wtsc_pkg::OPEN_BUS;
                    wtsc_pkg::ADDR_FREQ_HI:
                        read_value = {1'b0, len_en_reg, 6'd0} | wtsc_pkg::FREQ_READ_MASK;
                    default:                read_value = 8'd0;
                endcase
            end
        end
    end

    always_comb
    begin
        timer_next       = timer_reg;
        nibble_pos_next  = nibble_pos_reg;
        since_fetch_next = since_fetch_reg;
        last_idx_next    = last_idx_reg;
        freq_next        = freq_reg;
        vol_next         = vol_reg;
        dac_next         = dac_reg;
        enabled_next     = enabled_reg;
        len_en_next      = len_en_reg;
        held_next        = held_reg;

        unique case (item.kind)
            wtsc_pkg::KIND_TICK:
            begin
                if (since_fetch_reg < wtsc_pkg::FETCH_WINDOW)
                begin
                    since_fetch_next = since_fetch_reg + 2'd1;
                end
                if (timer_reg <= 13'd1)
                begin
                    timer_next = reload;
                    if (enabled_reg)
                    begin
                        since_fetch_next = 2'd0;
                        last_idx_next    = nibble_pos_reg[4:1];
                        held_next        = nib_scaled;
                        nibble_pos_next  = nibble_pos_reg + 5'd1;
                    end
                    else
                    begin
                        held_next = 4'd0;
                    end
                end
                else
                begin
                    timer_next = timer_reg - 13'd1;
                end
            end
            wtsc_pkg::KIND_READ:
            begin
                timer_next = timer_reg;
            end
            wtsc_pkg::KIND_WRITE:
            begin
                unique case (item.reg_addr)
                    wtsc_pkg::ADDR_DAC:
                    begin
                        dac_next     = item.reg_wdata[7];
                        enabled_next = enabled_reg && item.reg_wdata[7];
                    end
                    wtsc_pkg::ADDR_VOLUME:
                    begin
                        vol_next = item.reg_wdata[6:5];
                    end
                    wtsc_pkg::ADDR_FREQ_LO:
                    begin
                        freq_next = {freq_reg[10:8], item.reg_wdata};
                    end
                    wtsc_pkg::ADDR_FREQ_HI:
                    begin
                        len_en_next = item.reg_wdata[6];
                        freq_next   = {item.reg_wdata[2:0], freq_reg[7:0]};
                        if (item.reg_wdata[7])
                        begin
                            timer_next      = wtsc_pkg::TRIGGER_DELAY;
                            nibble_pos_next = 5'd0;
                            last_idx_next   = 4'd0;
                            enabled_next    = dac_reg;
                        end
                    end
                    default:
                    begin
                        timer_next = timer_reg;
                    end
                endcase
            end
            default:
            begin
                enabled_next     = 1'b0;
                dac_next         = 1'b0;
                len_en_next      = 1'b0;
                nibble_pos_next  = 5'd0;
                freq_next        = 11'd0;
                vol_next         = 2'd0;
                since_fetch_next = 2'd0;
                last_idx_next    = 4'd0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timer_reg       <= 13'd0;
            nibble_pos_reg  <= wtsc_pkg::NIBBLE_POS_INIT;
            since_fetch_reg <= 2'd0;
            last_idx_reg    <= 4'd0;
            freq_reg        <= 11'd0;
            vol_reg         <= 2'd0;
            dac_reg         <= 1'b0;
            enabled_reg     <= 1'b0;
            len_en_reg      <= 1'b0;
            held_reg        <= 4'd0;
        end
        else if (step)
        begin
            timer_reg       <= timer_next;
            nibble_pos_reg  <= nibble_pos_next;
            since_fetch_reg <= since_fetch_next;
            last_idx_reg    <= last_idx_next;
            freq_reg        <= freq_next;
            vol_reg         <= vol_next;
            dac_reg         <= dac_next;
            enabled_reg     <= enabled_next;
            len_en_reg      <= len_en_next;
            held_reg        <= held_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            if (corrupt_row)
            begin
                for (int j = 0; j < 4; j++)
                begin
                    wave_ram_reg[4'(j)] <= row_data[2'(j)];
                end
            end
            else if (corrupt_byte0)
            begin
                wave_ram_reg[0] <= rd_byte;
            end
            else if (ram_we)
            begin
                wave_ram_reg[rd_idx] <= item.reg_wdata;
            end
        end
    end

    assign result.reg_rdata  = read_value;
    assign result.sample     = held_next;
    assign result.channel_on = enabled_next;

    assign status.dac_on  = dac_reg;
    assign status.enabled = enabled_reg;

endmodule

`default_nettype wire

### tb/sv/tb_top.sv
// Self-checking stream testbench for the wave table sound channel.
`timescale 1ns / 1ps

module tb_top;

    import wtsc_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 200;
    localparam int PHASE_REQUESTS = 210;

    // Shadow copy of the channel state; it predicts the result of every request.
    class wave_channel_shadow;
        bit          color_mode;
        logic [7:0]  wave_bytes [WAVE_BYTES];
        logic [12:0] timer;
        logic [4:0]  pos;
        logic [1:0]  since_fetch;
        logic [3:0]  last_idx;
        logic [10:0] freq;
        logic [1:0]  vol;
        bit          dac_on;
        bit          enabled;
        bit          len_en;
        logic [3:0]  held;
        result_t     expected_results [$];
        int          errors;

        function new();
            color_mode = 1'b0;
            foreach (wave_bytes[i])
                wave_bytes[i] = 8'h00;
            timer = '0;
            pos = NIBBLE_POS_INIT;
            since_fetch = '0;
            last_idx = '0;
            freq = '0;
            vol = '0;
            dac_on = 1'b0;
            enabled = 1'b0;
            len_en = 1'b0;
            held = '0;
            errors = 0;
        endfunction

        // While playing, the table is reachable only near a fetch in monochrome mode.
        function bit wave_open();
            return (since_fetch < FETCH_WINDOW) || color_mode;
        endfunction

        function logic [7:0] read_reg(logic [7:0] a);
            if (a[7:4] == WAVE_PAGE)
            begin
                if (enabled)
                    return wave_open() ? wave_bytes[last_idx] : OPEN_BUS;
                return wave_bytes[a[3:0]];
            end
            case (a)
                ADDR_DAC:     return {dac_on, 7'd0} | DAC_READ_MASK;
                ADDR_LENGTH:  return OPEN_BUS;
                ADDR_VOLUME:  return {1'b0, vol, 5'd0} | VOLUME_READ_MASK;
                ADDR_FREQ_LO: return OPEN_BUS;
                ADDR_FREQ_HI: return {1'b0, len_en, 6'd0} | FREQ_READ_MASK;
                default:      return 8'h00;
            endcase
        endfunction

        function void trigger();
            logic [3:0] b;
            b = pos[4:1];
            // A monochrome trigger just as a fetch is due copies bytes to the front.
            if (enabled && timer == CORRUPT_TIMER && !color_mode)
            begin
                if (b < 4)
                    wave_bytes[0] = wave_bytes[b];
                else
                    for (int i = 0; i < 4; i++)
                        wave_bytes[i] = wave_bytes[{b[3:2], 2'b00} + i];
            end
            timer = TRIGGER_DELAY;
            pos = '0;
            last_idx = '0;
            enabled = dac_on;
        endfunction

        function void write_reg(logic [7:0] a, logic [7:0] v);
            if (a[7:4] == WAVE_PAGE)
            begin
                if (enabled)
                begin
                    if (wave_open())
                        wave_bytes[last_idx] = v;
                end
                else
                begin
                    wave_bytes[a[3:0]] = v;
                end
                return;
            end
            case (a)
                ADDR_DAC:
                begin
                    dac_on = v[7];
                    enabled = enabled && dac_on;
                end
                ADDR_VOLUME:  vol = v[6:5];
                ADDR_FREQ_LO: freq[7:0] = v;
                ADDR_FREQ_HI:
                begin
                    len_en = v[6];
                    freq[10:8] = v[2:0];
                    if (v[7])
                        trigger();
                end
                default: ;
            endcase
        endfunction

        function void tick();
            logic [7:0] byte_val;
            logic [3:0] nib;
            if (since_fetch < FETCH_WINDOW)
                since_fetch++;
            if (timer <= 13'd1)
            begin
                timer = 13'((2048 - int'(freq)) * 2);
                if (enabled)
                begin
                    since_fetch = '0;
                    last_idx = pos[4:1];
                    byte_val = wave_bytes[last_idx];
                    nib = pos[0] ? byte_val[3:0] : byte_val[7:4];
                    if (vol != 2'd0)
                        nib = nib >> (vol - 2'd1);
                    else
                        nib = '0;
                    held = nib;
                    pos = pos + 5'd1;
                end
                else
                begin
                    held = '0;
                end
            end
            else
            begin
                timer--;
            end
        endfunction

        function void shut_down();
            enabled = 1'b0;
            dac_on = 1'b0;
            len_en = 1'b0;
            pos = '0;
            freq = '0;
            vol = '0;
            since_fetch = '0;
            last_idx = '0;
        endfunction

        function void note_request(kind_t kind, logic [7:0] addr, logic [7:0] data);
            result_t r;
            r.reg_rdata = 8'h00;
            case (kind)
                KIND_TICK:  tick();
                KIND_READ:  r.reg_rdata = read_reg(addr);
                KIND_WRITE: write_reg(addr, data);
                default:    shut_down();
            endcase
            r.sample = held;
            r.channel_on = enabled;
            expected_results.push_back(r);
        endfunction

        function void check_result(logic [15:0] data);
            result_t got;
            result_t want;
            got = result_t'(data[12:0]);
            if (expected_results.size() == 0)
            begin
                $error("result %0h arrived with no request pending", data);
                errors++;
                return;
            end
            want = expected_results.pop_front();
            if (got.reg_rdata !== want.reg_rdata)
            begin
                $error("reg_rdata: expected %0h, got %0h", want.reg_rdata, got.reg_rdata);
                errors++;
            end
            if (got.sample !== want.sample)
            begin
                $error("sample: expected %0h, got %0h", want.sample, got.sample);
                errors++;
            end
            if (got.channel_on !== want.channel_on)
            begin
                $error("channel_on: expected %0b, got %0b", want.channel_on, got.channel_on);
                errors++;
            end
        endfunction

        function int pending();
            return expected_results.size();
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_wen = 1'b0;
    logic        cfg_wdata = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = '0;       // [7:0] reg_addr, [15:8] reg_wdata
    logic [1:0]  s_tuser = KIND_TICK; // [1:0] kind
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;            // [7:0] reg_rdata, [11:8] sample, [12] channel_on

    wave_channel_shadow chan_model;
    int cycle_count = 0;
    int sent_count = 0;
    int burst_left = 0;
    int hold_seq = 0;

    wave_table_sound_channel_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            chan_model.check_result(m_tdata);
    end

    // Result side: the stall rate switches between random modes, plus requested long hold-offs.
    initial
    begin
        int hold_seen;
        int stall_pct;
        int mode_left;
        hold_seen = 0;
        stall_pct = 0;
        mode_left = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_seen != hold_seq)
            begin
                hold_seen = hold_seq;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            if (mode_left == 0)
            begin
                case ($urandom_range(0, 3))
                    0: stall_pct = 0;
                    1: stall_pct = 25;
                    2: stall_pct = 60;
                    default: stall_pct = 90;
                endcase
                mode_left = $urandom_range(16, 96);
            end
            mode_left--;
            m_tready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    task automatic send_request(input kind_t kind, input logic [7:0] addr,
                                input logic [7:0] data);
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, 6);
            burst_left = $urandom_range(1, 40);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser <= kind;
        s_tdata <= {data, addr};
        do @(posedge clk); while (!s_tready);
        chan_model.note_request(kind, addr, data);
        sent_count++;
    endtask

    task automatic write_color_mode(input bit value);
        s_tvalid <= 1'b0;
        while (chan_model.pending() != 0)
            @(posedge clk);
        @(posedge clk);
        cfg_wen <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_wen <= 1'b0;
        chan_model.color_mode = value;
    endtask

    task automatic random_request();
        int p;
        logic [7:0] data;
        p = $urandom_range(0, 99);
        data = 8'($urandom);
        if (p < 50)
            send_request(KIND_TICK, 8'($urandom), data);
        else if (p < 62)
            send_request(KIND_READ, {WAVE_PAGE, 4'($urandom)}, data);
        else if (p < 70)
            send_request(KIND_WRITE, {WAVE_PAGE, 4'($urandom)}, data);
        else if (p < 76)
            send_request(KIND_READ, 8'($urandom_range(ADDR_DAC, ADDR_FREQ_HI)), data);
        else if (p < 82)
            send_request(KIND_WRITE, ADDR_VOLUME, data);
        else if (p < 87)
            // Retrigger, keeping the period short so fetches keep coming.
            send_request(KIND_WRITE, ADDR_FREQ_HI, 8'h87 | (data & 8'h78));
        else if (p < 89)
            send_request(KIND_WRITE, ADDR_FREQ_LO, 8'($urandom_range(8'hF8, 8'hFF)));
        else if (p < 91)
            send_request(KIND_WRITE, ADDR_DAC, data);
        else if (p < 93)
            send_request(KIND_SHUTDOWN, 8'($urandom), data);
        else if (p < 96)
            send_request(KIND_READ, 8'($urandom), data);
        else
            send_request(KIND_WRITE, 8'($urandom), data);
    endtask

    // Mostly a full start of the channel followed by random traffic; sometimes just noise.
    task automatic play_sequence();
        int body;
        if ($urandom_range(0, 9) != 0)
        begin
            send_request(KIND_WRITE, ADDR_DAC, 8'h80 | 8'($urandom));
            send_request(KIND_WRITE, ADDR_VOLUME, 8'($urandom));
            send_request(KIND_WRITE, ADDR_FREQ_LO, 8'($urandom_range(8'hF0, 8'hFF)));
            send_request(KIND_WRITE, ADDR_FREQ_HI, 8'h87 | (8'($urandom) & 8'h78));
        end
        body = $urandom_range(8, 40);
        repeat (body) random_request();
    endtask

    task automatic run_phase(input bit color, input bit with_hold);
        int start;
        write_color_mode(color);
        if (with_hold)
            hold_seq <= hold_seq + 1;
        start = sent_count;
        while (sent_count - start < PHASE_REQUESTS)
            play_sequence();
    endtask

    initial
    begin
        chan_model = new();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        write_color_mode(1'b0);

        // The whole table is written first, so no fetch or read ever sees an unwritten byte.
        for (int i = 0; i < WAVE_BYTES; i++)
            send_request(KIND_WRITE, {WAVE_PAGE, 4'(i)},
                         (i == 0) ? 8'h00 : (i == WAVE_BYTES - 1) ? 8'hFF : 8'($urandom));

        send_request(KIND_READ, 8'h00, 8'h00);
        send_request(KIND_READ, 8'hFF, 8'hFF);
        send_request(KIND_WRITE, 8'h40, 8'hFF);
        send_request(KIND_READ, {WAVE_PAGE, 4'hF}, 8'h00);
        send_request(KIND_WRITE, ADDR_DAC, 8'h80);
        send_request(KIND_WRITE, ADDR_VOLUME, 8'h20);
        send_request(KIND_WRITE, ADDR_FREQ_LO, 8'hFF);
        send_request(KIND_WRITE, ADDR_FREQ_HI, 8'hC7);
        for (int a = ADDR_DAC; a <= ADDR_FREQ_HI; a++)
            send_request(KIND_READ, 8'(a), 8'h00);
        repeat (4) send_request(KIND_TICK, 8'h00, 8'h00);
        send_request(KIND_READ, {WAVE_PAGE, 4'h7}, 8'h00);
        send_request(KIND_WRITE, {WAVE_PAGE, 4'hA}, 8'h5A);
        send_request(KIND_WRITE, ADDR_FREQ_HI, 8'h87);
        send_request(KIND_WRITE, ADDR_VOLUME, 8'h60);
        repeat (2) send_request(KIND_TICK, 8'h00, 8'h00);
        send_request(KIND_WRITE, ADDR_DAC, 8'h00);
        send_request(KIND_SHUTDOWN, 8'h00, 8'h00);
        send_request(KIND_READ, ADDR_DAC, 8'h00);

        run_phase(1'b0, 1'b0);
        run_phase(1'b1, 1'b1);
        run_phase(1'b0, 1'b1);
        run_phase(1'b1, 1'b0);

        s_tvalid <= 1'b0;
        while (chan_model.pending() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (chan_model.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
